// ===== rtl/midpoint_circle_span_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circle span generator
// Shared wrappers for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_SPAN_GENERATOR_ASSERT_SVH
`define MIDPOINT_CIRCLE_SPAN_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCSG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsg_pkg
// Types and fixed widths shared by the circle span generator modules.
// ----------------------------------------------------------------------------
package mcsg_pkg;

    localparam int CIN_W      = 11;  // center coordinate width
    localparam int RAD_W      = 6;   // radius width
    localparam int OUT_W      = 13;  // span coordinate width
    localparam int X_W        = 7;   // x offset width
    localparam int Y_W        = 8;   // y offset width, signed
    localparam int D_W        = 12;  // decision value width, signed
    localparam int CNT_W      = 6;   // span sets emitted so far
    localparam int RESULT_CAP = 48;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic load;  // latch a new request and start the walk
        logic emit;  // register the current point and advance the walk
    } t_cmd;

    typedef struct packed {
        logic out_free;   // the output register can take a word this cycle
        logic step_last;  // the current point is the final one of the circle
    } t_sts;

endpackage

// ===== rtl/mcsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcsg_ctrl
// Sequencer for the circle walk: takes a request, then steps the datapath
// once for every span set that the output register can accept.
// ----------------------------------------------------------------------------
`include "midpoint_circle_span_generator_assert.svh"

module mcsg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mcsg_pkg::t_sts  i_sts,
    output mcsg_pkg::t_cmd  o_cmd
);

    mcsg_pkg::t_state r_state;
    mcsg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcsg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            mcsg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mcsg_pkg::ST_WALK;
                end
            end
            mcsg_pkg::ST_WALK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.step_last) begin
                        n_state = mcsg_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mcsg_pkg::ST_IDLE;
            end
        endcase
    end

    `MCSG_ASSERT_SAME(a_emit_needs_room, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free, "span set emitted into a full output register")
    `MCSG_ASSERT_NEXT(a_last_ends_walk, i_clk, i_rst_n, o_cmd.emit && i_sts.step_last, r_state == mcsg_pkg::ST_IDLE, "walk continued past the final span set")
    `MCSG_ASSERT_SAME(a_load_only_idle, i_clk, i_rst_n, o_cmd.load, !o_cmd.emit && r_state == mcsg_pkg::ST_IDLE, "request loaded while a walk is running")

endmodule

// ===== rtl/mcsg_datapath.sv =====
// ----------------------------------------------------------------------------
// mcsg_datapath
// Midpoint walk registers, span arithmetic and the output register.
// ----------------------------------------------------------------------------
`include "midpoint_circle_span_generator_assert.svh"

module mcsg_datapath #(
    parameter int MAX_RADIUS = 63,
    parameter int COORD_BITS = 11
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mcsg_pkg::t_cmd                        i_cmd,
    output mcsg_pkg::t_sts                        o_sts,
    input  logic        [mcsg_pkg::CIN_W-1:0]     i_center_x,
    input  logic        [mcsg_pkg::CIN_W-1:0]     i_center_y,
    input  logic        [mcsg_pkg::RAD_W-1:0]     i_radius,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mcsg_pkg::OUT_W-1:0]     o_row_near_up,
    output logic signed [mcsg_pkg::OUT_W-1:0]     o_row_near_down,
    output logic signed [mcsg_pkg::OUT_W-1:0]     o_near_left,
    output logic signed [mcsg_pkg::OUT_W-1:0]     o_near_right,
    output logic signed [mcsg_pkg::OUT_W-1:0]     o_row_far_up,
    output logic signed [mcsg_pkg::OUT_W-1:0]     o_row_far_down,
    output logic signed [mcsg_pkg::OUT_W-1:0]     o_far_left,
    output logic signed [mcsg_pkg::OUT_W-1:0]     o_far_right,
    output logic                                  o_last_span_set
);

    localparam int MASK_I = (COORD_BITS >= mcsg_pkg::CIN_W) ?
                            ((1 << mcsg_pkg::CIN_W) - 1) : ((1 << COORD_BITS) - 1);
    localparam logic [mcsg_pkg::CIN_W-1:0] COORD_MASK = mcsg_pkg::CIN_W'(MASK_I);
    localparam int RAD_MAX_I = (1 << mcsg_pkg::RAD_W) - 1;
    localparam logic [mcsg_pkg::RAD_W-1:0] RAD_CAP =
        mcsg_pkg::RAD_W'((MAX_RADIUS < RAD_MAX_I) ? MAX_RADIUS : RAD_MAX_I);
    localparam logic [mcsg_pkg::CNT_W-1:0] CNT_LAST = mcsg_pkg::CNT_W'(mcsg_pkg::RESULT_CAP - 1);

    logic        [mcsg_pkg::X_W-1:0]   r_x;
    logic signed [mcsg_pkg::Y_W-1:0]   r_y;
    logic signed [mcsg_pkg::D_W-1:0]   r_d;
    logic        [mcsg_pkg::CIN_W-1:0] r_cx;
    logic        [mcsg_pkg::CIN_W-1:0] r_cy;
    logic        [mcsg_pkg::CNT_W-1:0] r_cnt;
    logic                              r_out_valid;

    logic        [mcsg_pkg::X_W-1:0]   n_x;
    logic signed [mcsg_pkg::Y_W-1:0]   n_y;
    logic signed [mcsg_pkg::D_W-1:0]   n_d;

    logic        [mcsg_pkg::RAD_W-1:0] rad_sat;
    logic signed [mcsg_pkg::D_W-1:0]   x1_d;
    logic signed [mcsg_pkg::D_W-1:0]   y1_d;
    logic signed [mcsg_pkg::OUT_W-1:0] cx_e;
    logic signed [mcsg_pkg::OUT_W-1:0] cy_e;
    logic signed [mcsg_pkg::OUT_W-1:0] x_e;
    logic signed [mcsg_pkg::OUT_W-1:0] y_e;
    logic                              y_below_x;

    assign rad_sat = (i_radius > RAD_CAP) ? RAD_CAP : i_radius;

    // One midpoint step: x always advances, y drops when the decision is positive.
    always_comb begin
        n_x  = r_x + mcsg_pkg::X_W'(1);
        x1_d = signed'(mcsg_pkg::D_W'(n_x));
        if (r_d > 0) begin
            n_y  = r_y - mcsg_pkg::Y_W'(1);
            y1_d = mcsg_pkg::D_W'(n_y);
            n_d  = r_d + ((x1_d - y1_d) <<< 2) + mcsg_pkg::D_W'(10);
        end else begin
            n_y  = r_y;
            y1_d = mcsg_pkg::D_W'(r_y);
            n_d  = r_d + (x1_d <<< 2) + mcsg_pkg::D_W'(6);
        end
    end

    assign cx_e = signed'(mcsg_pkg::OUT_W'(r_cx));
    assign cy_e = signed'(mcsg_pkg::OUT_W'(r_cy));
    assign x_e  = signed'(mcsg_pkg::OUT_W'(r_x));
    assign y_e  = mcsg_pkg::OUT_W'(r_y);

    assign y_below_x = (mcsg_pkg::D_W'(r_y) < signed'(mcsg_pkg::D_W'(r_x)));

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.step_last = y_below_x || (r_cnt == CNT_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.emit) begin
                r_cnt <= r_cnt + mcsg_pkg::CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= i_center_x & COORD_MASK;
            r_cy <= i_center_y & COORD_MASK;
            r_x  <= '0;
            r_y  <= signed'(mcsg_pkg::Y_W'(rad_sat));
            r_d  <= mcsg_pkg::D_W'(3) - (signed'(mcsg_pkg::D_W'(rad_sat)) <<< 1);
        end else if (i_cmd.emit) begin
            r_x <= n_x;
            r_y <= n_y;
            r_d <= n_d;
        end
    end

    // The output word is captured from the point before it is advanced.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_row_near_up   <= cy_e + y_e;
            o_row_near_down <= cy_e - y_e;
            o_near_left     <= cx_e - x_e;
            o_near_right    <= cx_e + x_e;
            o_row_far_up    <= cy_e + x_e;
            o_row_far_down  <= cy_e - x_e;
            o_far_left      <= cx_e - y_e;
            o_far_right     <= cx_e + y_e;
            o_last_span_set <= o_sts.step_last;
        end
    end

    assign o_out_valid = r_out_valid;

    `MCSG_ASSERT_NEXT(a_x_advances, i_clk, i_rst_n, i_cmd.emit && !i_cmd.load, r_x == $past(r_x) + mcsg_pkg::X_W'(1), "x offset did not advance on a step")
    `MCSG_ASSERT_NEXT(a_word_posted, i_clk, i_rst_n, i_cmd.emit, r_out_valid, "emitted span set not shown at the output")
    `MCSG_ASSERT_SAME(a_cap_held, i_clk, i_rst_n, r_out_valid && o_last_span_set == 1'b0, r_cnt != '0, "non-final word pending with no span set counted")

endmodule

// ===== rtl/midpoint_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_span_generator
// Filled-circle span generator on the midpoint circle walk: one request in,
// one word of four horizontal spans out for each point of the walk.
// ----------------------------------------------------------------------------
//   Channel   Handshake                  Payload
//   request   i_in_valid / o_in_ready    i_center_x, i_center_y, i_radius
//   span set  o_out_valid / i_out_ready  o_row_*, o_near_*, o_far_*, o_last_span_set
//
// A request is taken while idle; then the walk emits one span set per cycle
// while the output register has room, about 0.71*r+2 sets for radius r, at
// most 48. The walk register loop (x, y, decision) sets the pace: one step
// per cycle unless the span set side stalls. The next request is accepted
// the cycle after the final set is registered; reset is synchronous, active low.
// ----------------------------------------------------------------------------
module midpoint_circle_span_generator #(
    parameter int MAX_RADIUS = 63,
    parameter int COORD_BITS = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic        [mcsg_pkg::CIN_W-1:0] i_center_x,
    input  logic        [mcsg_pkg::CIN_W-1:0] i_center_y,
    input  logic        [mcsg_pkg::RAD_W-1:0] i_radius,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mcsg_pkg::OUT_W-1:0] o_row_near_up,
    output logic signed [mcsg_pkg::OUT_W-1:0] o_row_near_down,
    output logic signed [mcsg_pkg::OUT_W-1:0] o_near_left,
    output logic signed [mcsg_pkg::OUT_W-1:0] o_near_right,
    output logic signed [mcsg_pkg::OUT_W-1:0] o_row_far_up,
    output logic signed [mcsg_pkg::OUT_W-1:0] o_row_far_down,
    output logic signed [mcsg_pkg::OUT_W-1:0] o_far_left,
    output logic signed [mcsg_pkg::OUT_W-1:0] o_far_right,
    output logic                              o_last_span_set
);

    mcsg_pkg::t_cmd cmd;
    mcsg_pkg::t_sts sts;

    mcsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mcsg_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_radius        (i_radius),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_row_near_up   (o_row_near_up),
        .o_row_near_down (o_row_near_down),
        .o_near_left     (o_near_left),
        .o_near_right    (o_near_right),
        .o_row_far_up    (o_row_far_up),
        .o_row_far_down  (o_row_far_down),
        .o_far_left      (o_far_left),
        .o_far_right     (o_far_right),
        .o_last_span_set (o_last_span_set)
    );

endmodule
